[rtl/core/sck_pkg.sv]
// ----------------------------------------------------------------------------
// sck_pkg: shared types and constants for the cubic spline pair kernel
// Transaction payloads, fixed-point constants and datapath widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sck_pkg;

  typedef struct packed {
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic        [30:0] own_h;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic        [30:0] other_h;
  } pair_t;

  typedef struct packed {
    logic        [31:0] kernel_value;
    logic signed [31:0] kernel_gradient;
    logic               saturated;
  } result_t;

  // Datapath widths.
  localparam int R_W = 32;  // distance, raw Q16.16
  localparam int H_W = 31;  // smoothing length
  localparam int Q_W = 32;  // q = r/h in Q2.30
  localparam int N_W = 50;  // scaled numerator of the final division
  localparam int D_W = 62;  // h squared
  localparam int POLY_LAT = 6;

  // Fixed-point constants (Q30 and Q32, rounded to nearest).
  localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
  localparam logic [31:0] Q30_TWO   = 32'h8000_0000;
  localparam logic [31:0] Q30_TWO3  = 32'd715827883;
  localparam logic [31:0] K_INNER   = 32'd2300875337;
  localparam logic [31:0] K_OUTER   = 32'd383479223;
  localparam logic [31:0] INV_PI    = 32'd1367130551;
  localparam logic [31:0] Q32_TWO3  = 32'd2863311531;

endpackage

[rtl/core/sck_isqrt.sv]
// ----------------------------------------------------------------------------
// sck_isqrt: pipelined integer square root
// Floor square root of a 64-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sck_isqrt #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [63:0]      rad,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [31:0]      root,
  output logic [TAG_W-1:0] out_tag
);

  localparam int STG = 32;

  logic [32:0]      rem_q  [STG-1];
  logic [63:0]      rad_q  [STG-1];
  logic [31:0]      root_q [STG];
  logic [TAG_W-1:0] tag_q  [STG];
  logic             vld_q  [STG];

  logic [32:0]      rem_n  [STG-1];
  logic [63:0]      rad_n  [STG-1];
  logic [31:0]      root_n [STG];

  always_comb begin
    logic [34:0] rs;
    logic [34:0] tr;
    logic [32:0] rc;
    logic [63:0] vc;
    logic [31:0] oc;
    for (int k = 0; k < STG; k++) begin
      if (k == 0) begin
        rc = '0;
        vc = rad;
        oc = '0;
      end else begin
        rc = rem_q[k-1];
        vc = rad_q[k-1];
        oc = root_q[k-1];
      end
      rs = {rc[32:0], vc[63:62]};
      tr = {1'b0, oc, 2'b01};
      if (rs >= tr) begin
        root_n[k] = {oc[30:0], 1'b1};
        if (k < STG - 1) begin
          rem_n[k] = 33'(rs - tr);
        end
      end else begin
        root_n[k] = {oc[30:0], 1'b0};
        if (k < STG - 1) begin
          rem_n[k] = rs[32:0];
        end
      end
      if (k < STG - 1) begin
        rad_n[k] = {vc[61:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STG - 1; k++) begin
        rem_q[k] <= rem_n[k];
        rad_q[k] <= rad_n[k];
      end
      for (int k = 0; k < STG; k++) begin
        root_q[k] <= root_n[k];
      end
      tag_q[0] <= in_tag;
      for (int k = 1; k < STG; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STG; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid;
      for (int k = 1; k < STG; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign out_valid = vld_q[STG-1];
  assign root      = root_q[STG-1];
  assign out_tag   = tag_q[STG-1];

endmodule

[rtl/core/sck_div.sv]
// ----------------------------------------------------------------------------
// sck_div: pipelined restoring divider, several lanes in lockstep
// One quotient bit per register stage; lanes share valid and sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sck_div #(
  parameter int LANES = 1,
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int QUO_W = 8,
  parameter int TAG_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] num,
  input  logic [LANES-1:0][DEN_W-1:0] den,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_valid,
  output logic [LANES-1:0][QUO_W-1:0] quo,
  output logic [TAG_W-1:0]            out_tag
);

  // The quotient must fit QUO_W bits; the high numerator bits seed the
  // partial remainder.
  localparam int HI_W = NUM_W - QUO_W;
  localparam int STG  = QUO_W;

  logic [DEN_W-1:0] rem_init [LANES];

  logic [DEN_W-1:0] rem_q [LANES][STG-1];
  logic [DEN_W-1:0] den_q [LANES][STG-1];
  logic [QUO_W-1:0] nq_q  [LANES][STG];
  logic [DEN_W-1:0] rem_n [LANES][STG-1];
  logic [DEN_W-1:0] den_n [LANES][STG-1];
  logic [QUO_W-1:0] nq_n  [LANES][STG];
  logic [TAG_W-1:0] tag_q [STG];
  logic             vld_q [STG];

  generate
    if (HI_W > 0) begin : g_hi
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_init[l] = DEN_W'(num[l][NUM_W-1:QUO_W]);
        end
      end
    end else begin : g_nohi
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_init[l] = '0;
        end
      end
    end
  endgenerate

  // The low numerator bits and the quotient share one shift register.
  always_comb begin
    logic [DEN_W-1:0] rc;
    logic [QUO_W-1:0] nc;
    logic [DEN_W-1:0] dc;
    logic [DEN_W:0]   trial;
    logic             ge;
    for (int l = 0; l < LANES; l++) begin
      for (int k = 0; k < STG; k++) begin
        if (k == 0) begin
          rc = rem_init[l];
          nc = num[l][QUO_W-1:0];
          dc = den[l];
        end else begin
          rc = rem_q[l][k-1];
          nc = nq_q[l][k-1];
          dc = den_q[l][k-1];
        end
        trial = {rc, nc[QUO_W-1]};
        ge    = (trial >= {1'b0, dc});
        nq_n[l][k] = {nc[QUO_W-2:0], ge};
        if (k < STG - 1) begin
          rem_n[l][k] = ge ? DEN_W'(trial - {1'b0, dc}) : DEN_W'(trial);
          den_n[l][k] = dc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        for (int k = 0; k < STG - 1; k++) begin
          rem_q[l][k] <= rem_n[l][k];
          den_q[l][k] <= den_n[l][k];
        end
        for (int k = 0; k < STG; k++) begin
          nq_q[l][k] <= nq_n[l][k];
        end
      end
      tag_q[0] <= in_tag;
      for (int k = 1; k < STG; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STG; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid;
      for (int k = 1; k < STG; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = nq_q[l][STG-1];
    end
  end

  assign out_valid = vld_q[STG-1];
  assign out_tag   = tag_q[STG-1];

endmodule

[rtl/core/sck_poly.sv]
// ----------------------------------------------------------------------------
// sck_poly: spline polynomial for one smoothing length
// Six register stages from q to the numerators and divisor of the final
// scaling by 1/h^2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sck_poly (
  input  logic                      clk,
  input  logic                      en,
  input  logic [sck_pkg::Q_W-1:0]   q,
  input  logic                      inner,
  input  logic                      zero,
  input  logic [sck_pkg::H_W-1:0]   h,
  output logic [sck_pkg::N_W-1:0]   num_w,
  output logic [sck_pkg::N_W-1:0]   num_g,
  output logic [sck_pkg::D_W-1:0]   den
);

  import sck_pkg::*;

  logic [30:0]    s1_x;
  logic           s1_inner;
  logic           s1_zero;
  logic [H_W-1:0] s1_h;

  logic [30:0]    s2_x;
  logic [30:0]    s2_x2;
  logic           s2_inner;
  logic           s2_zero;
  logic [H_W-1:0] s2_h;

  logic [30:0]    s3_x2;
  logic [30:0]    s3_x3;
  logic [31:0]    s3_mag;
  logic           s3_inner;
  logic           s3_zero;
  logic [H_W-1:0] s3_h;

  logic [31:0]    s4_poly;
  logic [31:0]    s4_mag;
  logic           s4_inner;
  logic           s4_zero;
  logic [H_W-1:0] s4_h;

  logic [31:0]    s5_w30;
  logic [31:0]    s5_mag;
  logic [D_W-1:0] s5_h2;
  logic           s5_zero;

  logic [31:0] qc;
  logic [31:0] x1;
  logic [61:0] sq;
  logic [61:0] cu;
  logic [33:0] x_by3;
  logic [34:0] x2_by9;
  logic [32:0] x2_by3;
  logic [31:0] mag_c;
  logic [31:0] poly_c;
  logic [63:0] pk;
  logic [63:0] nw;
  logic [63:0] ng;

  // Inner piece works on q, outer piece on t = 2 - q; both stay within [0, 1].
  always_comb begin
    if (inner) begin
      qc = (q > Q30_ONE) ? Q30_ONE : q;
      x1 = qc;
    end else begin
      qc = (q > Q30_TWO) ? Q30_TWO : q;
      x1 = Q30_TWO - qc;
    end
  end

  assign sq     = 62'(s1_x) * 62'(s1_x);
  assign cu     = 62'(s2_x2) * 62'(s2_x);
  assign x_by3  = 34'(s2_x) * 34'd3;
  assign x2_by9 = 35'(s2_x2) * 35'd9;
  assign x2_by3 = 33'(s2_x2) * 33'd3;
  assign mag_c  = s2_inner ? 32'(x_by3 - 34'(x2_by9 >> 2)) : 32'(x2_by3 >> 2);
  assign poly_c = s3_inner ? (Q30_TWO3 + 32'(s3_x3 >> 1) - 32'(s3_x2)) : 32'(s3_x3);
  assign pk     = 64'(s4_poly) * 64'(s4_inner ? K_INNER : K_OUTER);
  assign nw     = 64'(s5_w30) * 64'(INV_PI);
  assign ng     = 64'(s5_mag) * 64'(Q32_TWO3);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x     <= x1[30:0];
      s1_inner <= inner;
      s1_zero  <= zero;
      s1_h     <= h;

      s2_x     <= s1_x;
      s2_x2    <= sq[60:30];
      s2_inner <= s1_inner;
      s2_zero  <= s1_zero;
      s2_h     <= s1_h;

      s3_x2    <= s2_x2;
      s3_x3    <= cu[60:30];
      s3_mag   <= mag_c;
      s3_inner <= s2_inner;
      s3_zero  <= s2_zero;
      s3_h     <= s2_h;

      s4_poly  <= poly_c;
      s4_mag   <= s3_mag;
      s4_inner <= s3_inner;
      s4_zero  <= s3_zero;
      s4_h     <= s3_h;

      s5_w30   <= pk[61:30];
      s5_mag   <= s4_mag;
      s5_h2    <= D_W'(s4_h) * D_W'(s4_h);
      s5_zero  <= s4_zero;

      // A side with no contribution divides zero by one.
      num_w    <= s5_zero ? '0 : nw[63:14];
      num_g    <= s5_zero ? '0 : ng[63:14];
      den      <= s5_zero ? D_W'(1) : s5_h2;
    end
  end

endmodule

[rtl/core/sph_cubic_spline_pair_kernel.sv]
// ----------------------------------------------------------------------------
// sph_cubic_spline_pair_kernel: symmetrized 2D cubic spline kernel, one pair
// The pipeline holds the 32-stage square root, the 32-stage q divider and the
// 50-stage 1/h^2 divider.
// Throughput: one transaction per cycle while the skid buffer is empty; a two-entry
// output register and skid buffer let the pipeline advance while a result waits.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_cubic_spline_pair_kernel (
  input  logic             clk,
  input  logic             rst,
  input  logic             pair_valid,
  output logic             pair_stall,
  input  sck_pkg::pair_t   pair,
  output logic             result_valid,
  input  logic             result_stall,
  output sck_pkg::result_t result
);

  import sck_pkg::*;

  typedef struct packed {
    logic           far;
    logic           dxz;
    logic           dxneg;
    logic [H_W-1:0] ha;
    logic [H_W-1:0] hb;
  } isq_tag_t;

  typedef struct packed {
    logic           zero_a;
    logic           inner_a;
    logic           zero_b;
    logic           inner_b;
    logic           dxz;
    logic           dxneg;
    logic [H_W-1:0] ha;
    logic [H_W-1:0] hb;
  } qdiv_tag_t;

  localparam int ISQ_TAG_W  = $bits(isq_tag_t);
  localparam int QDIV_TAG_W = $bits(qdiv_tag_t);

  logic    en;
  logic    skid_v;
  result_t skid;
  result_t res_c;

  // Front stages.
  logic               s1_v;
  logic signed [32:0] s1_dx;
  logic signed [32:0] s1_dy;
  logic [H_W-1:0]     s1_ha;
  logic [H_W-1:0]     s1_hb;

  logic               s2_v;
  logic [31:0]        s2_ax;
  logic [31:0]        s2_ay;
  logic               s2_dxz;
  logic               s2_dxneg;
  logic [H_W-1:0]     s2_ha;
  logic [H_W-1:0]     s2_hb;

  logic               s3_v;
  logic [63:0]        s3_sx;
  logic [63:0]        s3_sy;
  logic               s3_dxz;
  logic               s3_dxneg;
  logic [H_W-1:0]     s3_ha;
  logic [H_W-1:0]     s3_hb;

  logic               s4_v;
  logic [64:0]        d2_sum;
  logic [63:0]        s4_d2;
  isq_tag_t           s4_tag;

  logic               sq_v;
  logic [R_W-1:0]     sq_r;
  isq_tag_t           sq_tag;

  logic               s5_v;
  logic [R_W-1:0]     s5_r;
  qdiv_tag_t          s5_tag;
  qdiv_tag_t          s5_tag_c;

  logic                    qd_v;
  logic [1:0][61:0]        qd_num;
  logic [1:0][H_W-1:0]     qd_den;
  logic [1:0][Q_W-1:0]     qd_q;
  qdiv_tag_t               qd_tag;

  logic               pl_v     [POLY_LAT];
  logic               pl_dxz   [POLY_LAT];
  logic               pl_dxneg [POLY_LAT];

  logic [3:0][N_W-1:0] fd_num;
  logic [3:0][D_W-1:0] fd_den;
  logic [3:0][N_W-1:0] fd_q;
  logic [1:0]          fd_tag;
  logic                fd_v;

  logic           f_v;
  logic [N_W-1:0] f_wavg;
  logic [N_W-1:0] f_gavg;
  logic           f_dxz;
  logic           f_dxneg;

  // The pipeline advances whenever the skid buffer is empty.
  assign en         = !skid_v;
  assign pair_stall = skid_v;

  assign d2_sum = 65'(s3_sx) + 65'(s3_sy);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx    <= {pair.own_x[31], pair.own_x} - {pair.other_x[31], pair.other_x};
      s1_dy    <= {pair.own_y[31], pair.own_y} - {pair.other_y[31], pair.other_y};
      s1_ha    <= pair.own_h;
      s1_hb    <= pair.other_h;

      s2_ax    <= s1_dx[32] ? 32'(-s1_dx) : 32'(s1_dx);
      s2_ay    <= s1_dy[32] ? 32'(-s1_dy) : 32'(s1_dy);
      s2_dxz   <= (s1_dx == '0);
      s2_dxneg <= s1_dx[32];
      s2_ha    <= s1_ha;
      s2_hb    <= s1_hb;

      s3_sx    <= 64'(s2_ax) * 64'(s2_ax);
      s3_sy    <= 64'(s2_ay) * 64'(s2_ay);
      s3_dxz   <= s2_dxz;
      s3_dxneg <= s2_dxneg;
      s3_ha    <= s2_ha;
      s3_hb    <= s2_hb;

      // A carry out of the squared distance means r is beyond any 2h.
      s4_d2        <= d2_sum[63:0];
      s4_tag.far   <= d2_sum[64];
      s4_tag.dxz   <= s3_dxz;
      s4_tag.dxneg <= s3_dxneg;
      s4_tag.ha    <= s3_ha;
      s4_tag.hb    <= s3_hb;

      s5_r   <= sq_r;
      s5_tag <= s5_tag_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else if (en) begin
      s1_v <= pair_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= sq_v;
    end
  end

  sck_isqrt #(
    .TAG_W (ISQ_TAG_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_v),
    .rad       (s4_d2),
    .in_tag    (s4_tag),
    .out_valid (sq_v),
    .root      (sq_r),
    .out_tag   (sq_tag)
  );

  // Region selection for each smoothing length.
  always_comb begin
    s5_tag_c.zero_a  = (sq_tag.ha == '0) || sq_tag.far || (sq_r > {sq_tag.ha, 1'b0});
    s5_tag_c.inner_a = (sq_r <= {1'b0, sq_tag.ha});
    s5_tag_c.zero_b  = (sq_tag.hb == '0) || sq_tag.far || (sq_r > {sq_tag.hb, 1'b0});
    s5_tag_c.inner_b = (sq_r <= {1'b0, sq_tag.hb});
    s5_tag_c.dxz     = sq_tag.dxz;
    s5_tag_c.dxneg   = sq_tag.dxneg;
    s5_tag_c.ha      = sq_tag.ha;
    s5_tag_c.hb      = sq_tag.hb;
  end

  assign qd_num[0] = {s5_r, 30'd0};
  assign qd_num[1] = {s5_r, 30'd0};
  assign qd_den[0] = s5_tag.ha;
  assign qd_den[1] = s5_tag.hb;

  sck_div #(
    .LANES (2),
    .NUM_W (62),
    .DEN_W (H_W),
    .QUO_W (Q_W),
    .TAG_W (QDIV_TAG_W)
  ) u_qdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_v),
    .num       (qd_num),
    .den       (qd_den),
    .in_tag    (s5_tag),
    .out_valid (qd_v),
    .quo       (qd_q),
    .out_tag   (qd_tag)
  );

  sck_poly u_poly_a (
    .clk   (clk),
    .en    (en),
    .q     (qd_q[0]),
    .inner (qd_tag.inner_a),
    .zero  (qd_tag.zero_a),
    .h     (qd_tag.ha),
    .num_w (fd_num[0]),
    .num_g (fd_num[2]),
    .den   (fd_den[0])
  );

  sck_poly u_poly_b (
    .clk   (clk),
    .en    (en),
    .q     (qd_q[1]),
    .inner (qd_tag.inner_b),
    .zero  (qd_tag.zero_b),
    .h     (qd_tag.hb),
    .num_w (fd_num[1]),
    .num_g (fd_num[3]),
    .den   (fd_den[1])
  );

  assign fd_den[2] = fd_den[0];
  assign fd_den[3] = fd_den[1];

  always_ff @(posedge clk) begin
    if (en) begin
      pl_dxz[0]   <= qd_tag.dxz;
      pl_dxneg[0] <= qd_tag.dxneg;
      for (int k = 1; k < POLY_LAT; k++) begin
        pl_dxz[k]   <= pl_dxz[k-1];
        pl_dxneg[k] <= pl_dxneg[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < POLY_LAT; k++) begin
        pl_v[k] <= 1'b0;
      end
    end else if (en) begin
      pl_v[0] <= qd_v;
      for (int k = 1; k < POLY_LAT; k++) begin
        pl_v[k] <= pl_v[k-1];
      end
    end
  end

  sck_div #(
    .LANES (4),
    .NUM_W (N_W),
    .DEN_W (D_W),
    .QUO_W (N_W),
    .TAG_W (2)
  ) u_hdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pl_v[POLY_LAT-1]),
    .num       (fd_num),
    .den       (fd_den),
    .in_tag    ({pl_dxz[POLY_LAT-1], pl_dxneg[POLY_LAT-1]}),
    .out_valid (fd_v),
    .quo       (fd_q),
    .out_tag   (fd_tag)
  );

  // Lanes: 0 and 1 are the kernel values, 2 and 3 the gradient magnitudes.
  always_ff @(posedge clk) begin
    if (en) begin
      f_wavg  <= (fd_q[0] >> 1) + (fd_q[1] >> 1) + N_W'(fd_q[0][0] & fd_q[1][0]);
      f_gavg  <= (fd_q[2] >> 1) + (fd_q[3] >> 1) + N_W'(fd_q[2][0] & fd_q[3][0]);
      f_dxz   <= fd_tag[1];
      f_dxneg <= fd_tag[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= fd_v;
    end
  end

  // Saturation and gradient sign; a positive x offset gives a negative slope.
  always_comb begin
    logic sat_w;
    logic sat_g;
    sat_w = |f_wavg[N_W-1:32];
    res_c.kernel_value = sat_w ? '1 : f_wavg[31:0];
    sat_g = 1'b0;
    priority if (f_dxz || (f_gavg == '0)) begin
      res_c.kernel_gradient = '0;
    end else if (!f_dxneg) begin
      if (f_gavg > N_W'(32'h8000_0000)) begin
        res_c.kernel_gradient = 32'sh8000_0000;
        sat_g = 1'b1;
      end else begin
        res_c.kernel_gradient = -f_gavg[31:0];
      end
    end else begin
      if (f_gavg > N_W'(32'h7FFF_FFFF)) begin
        res_c.kernel_gradient = 32'sh7FFF_FFFF;
        sat_g = 1'b1;
      end else begin
        res_c.kernel_gradient = f_gavg[31:0];
      end
    end
    res_c.saturated = sat_w | sat_g;
  end

  // Output register with a one-entry skid buffer behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (result_valid && result_stall) begin
      if (en && f_v) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      result_valid <= 1'b1;
      skid_v       <= 1'b0;
    end else begin
      result_valid <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && result_stall) begin
      if (!skid_v) begin
        skid <= res_c;
      end
    end else begin
      result <= skid_v ? skid : res_c;
    end
  end

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(result_valid && result_stall))
    else $error("skid buffer filled while the output was free");

  a_skid_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> result_valid)
    else $error("skid buffer holds a transaction behind an empty output");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.saturated) |->
      (result.kernel_value == 32'hFFFF_FFFF ||
       result.kernel_gradient == 32'sh7FFF_FFFF ||
       result.kernel_gradient == 32'sh8000_0000))
    else $error("saturated flag without a clipped result");

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the symmetrized cubic spline pair kernel
// Streams particle pairs through the kernel under random idling and a long
// result hold-off. A bit-exact fixed-point predictor builds the expected
// kernel value, gradient and saturation flag for each pair. Each result is
// checked in order against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class pair_scoreboard;
  sck_pkg::result_t expected_results[$];
  int errors = 0;

  static function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  static function logic [63:0] over_h_sq(logic [63:0] p, logic [63:0] c, logic [63:0] h);
    return ((p * c) / h) / (h << 14);
  endfunction

  // Kernel and gradient magnitude for one smoothing length.
  static function void spline_side(logic [63:0] r, bit far, logic [63:0] h,
                                   output logic [63:0] w, output logic [63:0] g);
    logic [63:0] q, q2, q3, t, t2, t3, poly, mag;
    w = 0;
    g = 0;
    if (h == 0 || far || r > 2 * h) return;
    q = (r << 30) / h;
    if (r <= h) begin
      if (q > 64'(sck_pkg::Q30_ONE)) q = 64'(sck_pkg::Q30_ONE);
      q2 = (q * q) >> 30;
      q3 = (q2 * q) >> 30;
      poly = 64'(sck_pkg::Q30_TWO3) + (q3 >> 1) - q2;
      poly = (poly * 64'(sck_pkg::K_INNER)) >> 30;
      mag = 3 * q - ((9 * q2) >> 2);
    end else begin
      if (q > 64'(sck_pkg::Q30_TWO)) q = 64'(sck_pkg::Q30_TWO);
      t = 64'(sck_pkg::Q30_TWO) - q;
      t2 = (t * t) >> 30;
      t3 = (t2 * t) >> 30;
      poly = (t3 * 64'(sck_pkg::K_OUTER)) >> 30;
      mag = (3 * t2) >> 2;
    end
    w = over_h_sq(poly, 64'(sck_pkg::INV_PI), h);
    g = over_h_sq(mag, 64'(sck_pkg::Q32_TWO3), h);
  endfunction

  function void note_pair(sck_pkg::pair_t p);
    longint dx, dy;
    logic [63:0] ax, ay, sx, d2, r, wa, ga, wb, gb, wavg, gavg;
    bit far;
    sck_pkg::result_t e;
    dx = longint'(p.own_x) - longint'(p.other_x);
    dy = longint'(p.own_y) - longint'(p.other_y);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    sx = ax * ax;
    d2 = sx + ay * ay;
    far = d2 < sx;
    r = far ? 64'd0 : int_sqrt(d2);
    spline_side(r, far, 64'(p.own_h), wa, ga);
    spline_side(r, far, 64'(p.other_h), wb, gb);
    wavg = (wa >> 1) + (wb >> 1) + (wa & wb & 64'd1);
    gavg = (ga >> 1) + (gb >> 1) + (ga & gb & 64'd1);
    e.saturated = 1'b0;
    if (wavg > 64'hFFFF_FFFF) begin
      e.kernel_value = 32'hFFFF_FFFF;
      e.saturated = 1'b1;
    end else begin
      e.kernel_value = wavg[31:0];
    end
    if (dx == 0 || gavg == 0) begin
      e.kernel_gradient = 0;
    end else if (dx > 0) begin
      if (gavg > 64'h8000_0000) begin
        gavg = 64'h8000_0000;
        e.saturated = 1'b1;
      end
      e.kernel_gradient = -gavg[31:0];
    end else begin
      if (gavg > 64'h7FFF_FFFF) begin
        gavg = 64'h7FFF_FFFF;
        e.saturated = 1'b1;
      end
      e.kernel_gradient = gavg[31:0];
    end
    expected_results.push_back(e);
  endfunction

  function void check_result(sck_pkg::result_t a);
    sck_pkg::result_t e;
    if (expected_results.size() == 0) begin
      $error("result with no pair outstanding");
      errors++;
      return;
    end
    e = expected_results.pop_front();
    if (a.kernel_value !== e.kernel_value) begin
      $error("kernel_value: expected %h, got %h", e.kernel_value, a.kernel_value);
      errors++;
    end
    if (a.kernel_gradient !== e.kernel_gradient) begin
      $error("kernel_gradient: expected %h, got %h", e.kernel_gradient, a.kernel_gradient);
      errors++;
    end
    if (a.saturated !== e.saturated) begin
      $error("saturated: expected %b, got %b", e.saturated, a.saturated);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import sck_pkg::*;

  localparam int RANDOM_PAIRS = 500;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLDOFF_CYCLES = 400;

  logic clk;
  logic rst;
  logic pair_valid;
  logic pair_stall;
  pair_t pair;
  logic result_valid;
  logic result_stall;
  result_t result;

  pair_scoreboard sb;
  int phase;
  bit holdoff_req;
  int quiet_cycles;

  sph_cubic_spline_pair_kernel dut (
    .clk(clk),
    .rst(rst),
    .pair_valid(pair_valid),
    .pair_stall(pair_stall),
    .pair(pair),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Both handshakes are sampled here, before this edge's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (pair_valid && !pair_stall) sb.note_pair(pair);
      if (result_valid && !result_stall) sb.check_result(result);
      if ((pair_valid && !pair_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stall by phase, plus one long hold-off on request.
  initial begin
    int hold_left;
    int pct;
    hold_left = 0;
    result_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (holdoff_req && hold_left == 0) begin
        hold_left = HOLDOFF_CYCLES;
        holdoff_req = 0;
      end
      pct = phase == 0 ? 88 : (phase == 1 ? 15 : 0);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < pct);
      end
    end
  end

  task automatic send_pair(pair_t p);
    int pct;
    pct = phase == 0 ? 15 : (phase == 1 ? 88 : 0);
    while ($urandom_range(99) < pct) begin
      pair_valid <= 1'b0;
      @(posedge clk);
    end
    pair <= p;
    pair_valid <= 1'b1;
    do @(posedge clk); while (pair_stall);
  endtask

  function automatic pair_t make_pair(logic signed [31:0] ox, logic signed [31:0] oy,
                                      logic [30:0] oh, logic signed [31:0] tx,
                                      logic signed [31:0] ty, logic [30:0] th);
    pair_t p;
    p.own_x = ox;
    p.own_y = oy;
    p.own_h = oh;
    p.other_x = tx;
    p.other_y = ty;
    p.other_h = th;
    return p;
  endfunction

  function automatic logic [30:0] rand_h();
    logic [30:0] h;
    h = 31'($urandom) >> $urandom_range(0, 30);
    return h == 0 ? 31'd1 : h;
  endfunction

  // Mostly pairs within a few smoothing lengths; some fully random.
  function automatic pair_t rand_pair();
    pair_t p;
    logic [63:0] span;
    logic [31:0] ddx, ddy;
    p.own_x = $urandom;
    p.own_y = $urandom;
    p.own_h = rand_h();
    p.other_h = $urandom_range(3) == 0 ? rand_h() : p.own_h + 31'($urandom_range(0, 7)) - 31'd3;
    if (p.other_h == 0) p.other_h = 1;
    if ($urandom_range(9) == 0) begin
      p.other_x = $urandom;
      p.other_y = $urandom;
      if ($urandom_range(1)) begin
        p.own_h = 31'($urandom);
        if (p.own_h == 0) p.own_h = 1;
      end
    end else begin
      span = 3 * 64'(p.own_h) / 2 + 1;
      ddx = 32'({$urandom, $urandom} % span);
      ddy = $urandom_range(4) == 0 ? 32'd0 : 32'({$urandom, $urandom} % span);
      if ($urandom_range(1)) ddx = -ddx;
      if ($urandom_range(1)) ddy = -ddy;
      if ($urandom_range(9) == 0) ddx = 0;
      p.other_x = p.own_x - ddx;
      p.other_y = p.own_y - ddy;
    end
    return p;
  endfunction

  initial begin
    pair_t directed[$];
    sb = new();
    phase = 0;
    holdoff_req = 0;
    quiet_cycles = 0;
    rst = 1'b1;
    pair_valid = 1'b0;
    pair = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(make_pair(0, 0, 1, 0, 0, 1));                // coincident, tiny h
    directed.push_back(make_pair(1, 0, 1, 0, 0, 1));                // r = h, gradient clips
    directed.push_back(make_pair(-1, 0, 1, 0, 0, 1));
    directed.push_back(make_pair(2, 0, 1, 0, 0, 1));                // r = 2h
    directed.push_back(make_pair(3, 0, 1, 0, 0, 1));                // beyond support
    directed.push_back(make_pair(0, 32'h0001_0000, 31'h10000, 0, 0, 31'h10000)); // zero dx
    directed.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF)); // huge distance
    directed.push_back(make_pair(32'h7FFF_FFFF, 0, 31'h7FFF_FFFF,
                                 32'h8000_0000, 0, 31'h7FFF_FFFF));
    directed.push_back(make_pair(32'h4000_0000, 32'hC000_0000, 31'h7FFF_FFFF,
                                 32'hC000_0000, 32'h4000_0000, 31'h7FFF_FFFF));
    directed.push_back(make_pair(32'h10000, 0, 31'h10000, 0, 0, 31'h7FFF_FFFF));
    directed.push_back(make_pair(32'h18000, 0, 31'h10000, 0, 0, 31'h20000)); // mixed regions
    directed.push_back(make_pair(32'h8000, 32'h8000, 31'h10000, 0, 0, 31'h10000));
    directed.push_back(make_pair(0, 0, 31'h10000, 32'h18000, 32'h8000, 31'h10000));
    directed.push_back(make_pair(5, 7, 3, 1, 2, 4));
    directed.push_back(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h5555_5555,
                                 0, 0, 31'h2AAA_AAAA));
    foreach (directed[i]) send_pair(directed[i]);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == RANDOM_PAIRS / 3) phase = 1;
      if (i == 2 * RANDOM_PAIRS / 3) phase = 2;
      if (i == 3 * RANDOM_PAIRS / 4) holdoff_req = 1;
      send_pair(rand_pair());
    end
    pair_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/sck_pkg.sv
rtl/core/sck_isqrt.sv
rtl/core/sck_div.sv
rtl/core/sck_poly.sv
rtl/core/sph_cubic_spline_pair_kernel.sv
test/tb_top.sv
